[rtl/sorted_timer_queue_assert.svh]
// Assertion macros for the timer queue.
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define STQ_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define STQ_ASSERT_IMPL(label, clk, rst_n, prop)
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/stq_pkg.sv]
//------------------------------------------------------------------------------
// stq_pkg
// Shared constants and types of the sorted timer queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;
    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;

    typedef enum logic [1:0] {
        K_SET    = 2'd0,
        K_CANCEL = 2'd1,
        K_TICK   = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        R_SET_ACK    = 2'd0,
        R_CANCEL_ACK = 2'd1,
        R_FIRED      = 2'd2,
        R_SUMMARY    = 2'd3
    } t_rkind;
endpackage
`default_nettype wire

[rtl/stq_ram.sv]
//------------------------------------------------------------------------------
// stq_ram
// Generic single-port-write, single-port-read RAM with registered read.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/sorted_timer_queue.sv]
//------------------------------------------------------------------------------
// sorted_timer_queue
// Deadline-ordered timer queue with a wrapping time counter.
//------------------------------------------------------------------------------
// Usage: an input item (kind, slot, delay, handler, tag) is accepted when
// i_valid is high and o_stall is low. Set and cancel items give one acknowledge
// result. A tick item gives one fired result per expired slot in deadline
// order, then a summary result. o_last marks the final result of an item.
// The block works on one item at a time. o_stall stays high from the accept
// until the final result is written, so the next item can go in the cycle after that.
// Slot payloads (deadline, handler, tag) live in a slot memory and the sorted
// order list lives in a second memory. Both memories have a registered read.
// A cancel of a queued slot searches the order list, then shifts the later
// entries down; a cancel of an idle slot, or a set of a slot out of range,
// goes straight to its result. A set of an idle slot writes the payload, scans
// the list for the first entry with a later deadline, then shifts the entries
// from there up; re-arming a queued slot first removes it as a cancel does.
// A tick on an empty queue gives its summary at once; otherwise each expired
// head is sent out and removed by shifting the entries behind it down, and a
// summary follows.
// Results go out through one output register. While the receiver stalls a held
// result, that result stays unchanged and the engine waits before it writes
// the next result. Reset clears time, the queued flags and the count. Only
// queued entries are ever read, so the memories need no clearing.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_timer_queue_assert.svh"
module sorted_timer_queue import stq_pkg::*; #(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [3:0]  i_slot,
    input  wire logic [30:0] i_delay,
    input  wire logic [7:0]  i_handler,
    input  wire logic [31:0] i_tag,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_result_kind,
    output logic [3:0]       o_fired_slot,
    output logic [7:0]       o_fired_handler,
    output logic [31:0]      o_fired_tag,
    output logic             o_flag,
    output logic [30:0]      o_next_delay,
    output logic             o_none_pending,
    output logic             o_last
);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int DW = TIME_BITS + 8 + 32;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND_RD, S_FIND_CK, S_DEL_RD, S_DEL_WR, S_WRSLOT,
        S_INS_RD, S_INS_CK, S_SHIFT_RD, S_SHIFT_WR, S_HEAD_RD, S_HEAD_DL,
        S_HEAD_CK, S_EMIT
    } t_state;

    t_state          r_state;
    logic [TIME_BITS-1:0] r_now;
    logic [SLOTS-1:0]     r_queued;
    logic [CW-1:0]        r_occ;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_pos;
    t_kind                r_kind;
    logic [3:0]           r_slot;
    logic [TIME_BITS-1:0] r_dl;
    logic [7:0]           r_hdl;
    logic [31:0]          r_tag;
    logic                 r_flag;
    logic                 r_tick;
    logic [SW-1:0]        r_head;

    // order memory
    logic          ord_we;
    logic [SW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    // slot memory
    logic          slt_we;
    logic [SW-1:0] slt_waddr, slt_raddr;
    logic [DW-1:0] slt_wdata, slt_rdata;

    stq_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_order (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_raddr(ord_raddr), .o_rdata(ord_rdata)
    );
    stq_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_slots (
        .i_clk(i_clk), .i_we(slt_we), .i_waddr(slt_waddr), .i_wdata(slt_wdata),
        .i_raddr(slt_raddr), .o_rdata(slt_rdata)
    );

    logic [TIME_BITS-1:0] mem_dl;
    logic [TIME_BITS-1:0] diff;
    logic                 is_later;
    logic                 slot_ok;
    logic                 out_free;
    logic [TIME_BITS-1:0] dly_ext;

    assign mem_dl   = slt_rdata[DW-1 -: TIME_BITS];
    assign out_free = !o_valid || !i_stall;
    assign slot_ok  = ({28'd0, r_slot} < 32'(SLOTS));
    // Compare candidate (memory deadline) against reference: later when the
    // wrapped difference is nonzero with a clear top bit.
    assign diff     = mem_dl - (r_tick ? r_now : r_dl);
    assign is_later = (diff != '0) && !diff[TIME_BITS-1];
    generate
        if (TIME_BITS > 31) begin : g_wide
            assign dly_ext = {{(TIME_BITS-31){1'b0}}, i_delay};
        end else begin : g_narrow
            assign dly_ext = i_delay[TIME_BITS-1:0];
        end
    endgenerate

    // Memory address and write control follow the state.
    always_comb begin
        ord_we    = 1'b0;
        ord_waddr = r_pos[SW-1:0];
        ord_wdata = ord_rdata;
        ord_raddr = r_idx[SW-1:0];
        slt_we    = 1'b0;
        slt_waddr = r_slot[SW-1:0];
        slt_wdata = {r_dl, r_hdl, r_tag};
        slt_raddr = ord_rdata;
        unique case (r_state)
            S_DEL_WR:   ord_we = 1'b1;
            // The shift moves order[r_idx-1] up to order[r_idx].
            S_SHIFT_RD: ord_raddr = r_idx[SW-1:0] - 1'b1;
            S_SHIFT_WR: begin
                ord_we    = 1'b1;
                ord_waddr = r_idx[SW-1:0];
            end
            S_WRSLOT:   slt_we = 1'b1;
            S_INS_CK:   ord_raddr = r_idx[SW-1:0];
            S_HEAD_DL:  slt_raddr = ord_rdata;
            S_EMIT: begin
                ord_we    = (r_kind == K_SET) && slot_ok;
                ord_wdata = r_slot[SW-1:0];
            end
            default: ;
        endcase
    end

    logic        out_wr;
    logic [1:0]  w_rk;
    logic [3:0]  w_slot;
    logic [7:0]  w_h;
    logic [31:0] w_tag;
    logic        w_fl;
    logic [30:0] w_nd;
    logic        w_np;
    logic        w_last;

    // Result to load into the output register in this cycle.
    always_comb begin
        out_wr = 1'b0;
        w_rk = R_SET_ACK; w_slot = '0; w_h = '0; w_tag = '0;
        w_fl = 1'b0; w_nd = '0; w_np = 1'b0; w_last = 1'b1;
        unique case (r_state)
            S_HEAD_RD: begin
                if (r_occ == '0 && out_free) begin
                    out_wr = 1'b1;
                    w_rk   = R_SUMMARY;
                    w_np   = 1'b1;
                end
            end
            S_HEAD_CK: begin
                if (r_tick && out_free) begin
                    out_wr = 1'b1;
                    if (is_later) begin
                        w_rk = R_SUMMARY;
                        w_nd = (TIME_BITS > 31 && diff[TIME_BITS-1:0] >
                                TIME_BITS'(31'h7FFFFFFF))
                               ? 31'h7FFFFFFF : 31'(diff);
                    end else begin
                        w_rk   = R_FIRED;
                        w_slot = 4'(r_head);
                        w_h    = slt_rdata[39:32];
                        w_tag  = slt_rdata[31:0];
                        w_last = 1'b0;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_wr = 1'b1;
                    w_rk   = (r_kind == K_SET) ? R_SET_ACK : R_CANCEL_ACK;
                    w_slot = r_slot;
                    w_fl   = r_flag;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_now    <= '0;
            r_queued <= '0;
            r_occ    <= '0;
            o_valid  <= 1'b0;
            o_stall  <= 1'b0;
        end else begin
            o_valid <= out_wr || (o_valid && i_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_kind <= t_kind'(i_kind);
                        r_slot <= i_slot;
                        r_hdl  <= i_handler;
                        r_tag  <= i_tag;
                        r_dl   <= r_now + dly_ext;
                        r_idx  <= '0;
                        r_tick <= 1'b0;
                        unique case (t_kind'(i_kind))
                            K_SET, K_CANCEL: begin
                                o_stall <= 1'b1;
                                r_state <= S_FIND_RD;
                            end
                            K_TICK: begin
                                o_stall <= 1'b1;
                                r_now   <= r_now + 1'b1;
                                r_tick  <= 1'b1;
                                r_state <= S_HEAD_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FIND_RD: begin
                    // Look for the slot's position only if it is queued.
                    if (!slot_ok || !r_queued[r_slot[SW-1:0]]) begin
                        r_flag  <= slot_ok && (r_kind == K_SET);
                        r_state <= (slot_ok && r_kind == K_SET) ? S_WRSLOT : S_EMIT;
                    end else begin
                        r_flag  <= (r_kind == K_CANCEL);
                        r_state <= S_FIND_CK;
                    end
                end
                S_FIND_CK: begin
                    // ord_rdata holds order[r_idx]
                    if (ord_rdata == r_slot[SW-1:0]) begin
                        r_pos   <= r_idx;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_DEL_RD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        if (r_idx + 1'b1 >= r_occ) begin
                            r_state <= S_DEL_RD;
                        end else begin
                            r_state <= S_FIND_RD;
                        end
                    end
                end
                S_DEL_RD: begin
                    if (r_idx >= r_occ) begin
                        r_occ    <= r_occ - 1'b1;
                        r_queued[r_slot[SW-1:0]] <= 1'b0;
                        r_state  <= r_tick ? S_HEAD_RD
                                  : ((r_kind == K_SET) ? S_WRSLOT : S_EMIT);
                        if (r_tick) r_idx <= '0;
                    end else begin
                        r_state <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    r_pos   <= r_pos + 1'b1;
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_DEL_RD;
                end
                S_WRSLOT: begin
                    r_idx   <= '0;
                    r_pos   <= r_occ;
                    r_state <= (r_occ == '0) ? S_EMIT : S_INS_RD;
                end
                S_INS_RD: begin
                    r_state <= S_INS_CK;
                end
                S_INS_CK: begin
                    r_state <= S_HEAD_CK;
                end
                S_HEAD_CK: begin
                    // Slot data of order[r_idx] is now in slt_rdata.
                    if (r_tick) begin
                        if (is_later) begin
                            if (out_free) begin
                                o_stall <= 1'b0;
                                r_state <= S_IDLE;
                            end
                        end else if (out_free) begin
                            r_slot  <= 4'(r_head);
                            r_pos   <= '0;
                            r_idx   <= CW'(1);
                            r_state <= S_DEL_RD;
                        end
                    end else if (is_later) begin
                        r_pos   <= r_idx;
                        r_idx   <= r_occ;
                        r_state <= S_SHIFT_RD;
                    end else if (r_idx + 1'b1 >= r_occ) begin
                        r_pos   <= r_occ;
                        r_state <= S_EMIT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_INS_RD;
                    end
                end
                S_SHIFT_RD: begin
                    // Move order[r_idx-1] up to r_idx, from the top down.
                    if (r_idx == r_pos) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    r_idx   <= r_idx - 1'b1;
                    r_state <= S_SHIFT_RD;
                end
                S_HEAD_RD: begin
                    r_idx <= '0;
                    if (r_occ == '0) begin
                        if (out_free) begin
                            o_stall <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_HEAD_DL;
                    end
                end
                S_HEAD_DL: begin
                    r_head  <= ord_rdata;
                    r_state <= S_HEAD_CK;
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_kind == K_SET && slot_ok) begin
                            r_occ <= r_occ + 1'b1;
                            r_queued[r_slot[SW-1:0]] <= 1'b1;
                        end
                        o_stall <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (out_wr) begin
            o_result_kind   <= w_rk;
            o_fired_slot    <= w_slot;
            o_fired_handler <= w_h;
            o_fired_tag     <= w_tag;
            o_flag          <= w_fl;
            o_next_delay    <= w_nd;
            o_none_pending  <= w_np;
            o_last          <= w_last;
        end
    end

    // Occupancy never exceeds the slot count.
    `STQ_ASSERT_IMPL(a_occ_range, i_clk, i_rst_n, r_occ <= CW'(SLOTS))
    // The input side is closed whenever the engine is busy.
    `STQ_ASSERT_IMPL(a_busy_stall, i_clk, i_rst_n, (r_state != S_IDLE) |-> o_stall)
    // The queued count and the number of queued flags agree when idle.
    `STQ_ASSERT_IMPL(a_occ_flags, i_clk, i_rst_n,
        (r_state == S_IDLE) |-> ($countones(r_queued) == int'(r_occ)))
    // The tag of a held result does not change while stalled.
    `STQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(o_fired_tag))
endmodule
`default_nettype wire

[tb/sorted_timer_queue_test.sv]
//------------------------------------------------------------------------------
// sorted_timer_queue_test
// Self-checking bench for the deadline-ordered timer queue. Timer set, cancel
// and tick items are sent with random gaps while the result side stalls at
// random. A behavioral copy of the timer list predicts every ack, firing and
// tick summary, and each result is compared field by field in order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module sorted_timer_queue_test;
    import stq_pkg::*;

    localparam int NSLOT = 16;

    // One expected result, with every field the block drives.
    typedef struct {
        t_rkind      rkind;
        logic [3:0]  slot;
        logic [7:0]  handler;
        logic [31:0] tag;
        logic        flag;
        logic [30:0] next_delay;
        logic        none_pending;
        logic        last;
    } timer_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_kind;
    logic [3:0]  i_slot;
    logic [30:0] i_delay;
    logic [7:0]  i_handler;
    logic [31:0] i_tag;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_result_kind;
    logic [3:0]  o_fired_slot;
    logic [7:0]  o_fired_handler;
    logic [31:0] o_fired_tag;
    logic        o_flag;
    logic [30:0] o_next_delay;
    logic        o_none_pending;
    logic        o_last;

    // Predicted contents of the block: time counter, per-slot payloads and
    // the list of armed slots sorted by deadline.
    logic [31:0]     clock_now;
    logic [31:0]     slot_deadline [NSLOT];
    logic [7:0]      slot_handler [NSLOT];
    logic [31:0]     slot_tag [NSLOT];
    logic            slot_armed [NSLOT];
    int              deadline_list [$];
    timer_result_t   results_due [$];

    int  fail_count;
    bit  quiet;   // when set, neither side idles

    sorted_timer_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_slot          (i_slot),
        .i_delay         (i_delay),
        .i_handler       (i_handler),
        .i_tag           (i_tag),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_kind   (o_result_kind),
        .o_fired_slot    (o_fired_slot),
        .o_fired_handler (o_fired_handler),
        .o_fired_tag     (o_fired_tag),
        .o_flag          (o_flag),
        .o_next_delay    (o_next_delay),
        .o_none_pending  (o_none_pending),
        .o_last          (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Deadline a is later than b when the wrapping difference is positive.
    function automatic bit is_later(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d != 0 && !d[31];
    endfunction

    function automatic timer_result_t make_result(t_rkind k, logic [3:0] s,
            logic [7:0] h, logic [31:0] t, logic f, logic [30:0] nd,
            logic np, logic l);
        timer_result_t r;
        r.rkind = k; r.slot = s; r.handler = h; r.tag = t; r.flag = f;
        r.next_delay = nd; r.none_pending = np; r.last = l;
        return r;
    endfunction

    task automatic unlink_timer(int s);
        foreach (deadline_list[i]) begin
            if (deadline_list[i] == s) begin
                deadline_list.delete(i);
                break;
            end
        end
        slot_armed[s] = 1'b0;
    endtask

    // Updates the predicted state for one accepted item and queues its results.
    task automatic predict_timer_item(t_kind k, logic [3:0] s, logic [30:0] d,
            logic [7:0] h, logic [31:0] t);
        int pos;
        int head;
        logic fresh;
        logic [31:0] gap;
        case (k)
            K_SET: begin
                fresh = !slot_armed[s];
                if (slot_armed[s]) unlink_timer(s);
                slot_handler[s] = h;
                slot_tag[s] = t;
                slot_deadline[s] = clock_now + {1'b0, d};
                // Behind every slot with an equal or earlier deadline.
                pos = deadline_list.size();
                foreach (deadline_list[i]) begin
                    if (is_later(slot_deadline[deadline_list[i]], slot_deadline[s])) begin
                        pos = i;
                        break;
                    end
                end
                deadline_list.insert(pos, s);
                slot_armed[s] = 1'b1;
                results_due.push_back(make_result(R_SET_ACK, s, 0, 0, fresh, 0, 0, 1));
            end
            K_CANCEL: begin
                fresh = slot_armed[s];
                if (slot_armed[s]) unlink_timer(s);
                results_due.push_back(make_result(R_CANCEL_ACK, s, 0, 0, fresh, 0, 0, 1));
            end
            K_TICK: begin
                clock_now = clock_now + 1;
                while (deadline_list.size() > 0 &&
                       !is_later(slot_deadline[deadline_list[0]], clock_now)) begin
                    head = deadline_list.pop_front();
                    slot_armed[head] = 1'b0;
                    results_due.push_back(make_result(R_FIRED, 4'(head), slot_handler[head],
                                                      slot_tag[head], 0, 0, 0, 0));
                end
                if (deadline_list.size() > 0) begin
                    gap = slot_deadline[deadline_list[0]] - clock_now;
                    results_due.push_back(make_result(R_SUMMARY, 0, 0, 0, 0,
                        gap[31] ? 31'h7fffffff : gap[30:0], 0, 1));
                end else begin
                    results_due.push_back(make_result(R_SUMMARY, 0, 0, 0, 0, 0, 1, 1));
                end
            end
            default: ;  // the unused kind is dropped by the block
        endcase
    endtask

    // Sends one item, with a random gap before it unless quiet is set.
    task automatic send_item(t_kind k, logic [3:0] s, logic [30:0] d,
            logic [7:0] h, logic [31:0] t);
        while (!quiet && $urandom_range(99) < 36) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= k;
        i_slot    <= s;
        i_delay   <= d;
        i_handler <= h;
        i_tag     <= t;
        do @(posedge i_clk); while (o_stall);
        predict_timer_item(k, s, d, h, t);
    endtask

    // Holds the input side until every predicted result has come out.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() > 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, and an in-order compare of each result.
    always @(posedge i_clk) begin
        timer_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                $error("unexpected result: kind %0d slot %0d", o_result_kind, o_fired_slot);
                fail_count++;
            end else begin
                want = results_due.pop_front();
                if (o_result_kind !== want.rkind) begin
                    $error("result_kind: expected %0d, got %0d", want.rkind, o_result_kind);
                    fail_count++;
                end
                if (o_fired_slot !== want.slot) begin
                    $error("fired_slot: expected %0d, got %0d", want.slot, o_fired_slot);
                    fail_count++;
                end
                if (o_fired_handler !== want.handler) begin
                    $error("fired_handler: expected %0h, got %0h", want.handler,
                           o_fired_handler);
                    fail_count++;
                end
                if (o_fired_tag !== want.tag) begin
                    $error("fired_tag: expected %0h, got %0h", want.tag, o_fired_tag);
                    fail_count++;
                end
                if (o_flag !== want.flag) begin
                    $error("flag: expected %0b, got %0b", want.flag, o_flag);
                    fail_count++;
                end
                if (o_next_delay !== want.next_delay) begin
                    $error("next_delay: expected %0d, got %0d", want.next_delay,
                           o_next_delay);
                    fail_count++;
                end
                if (o_none_pending !== want.none_pending) begin
                    $error("none_pending: expected %0b, got %0b", want.none_pending,
                           o_none_pending);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    fail_count++;
                end
            end
        end
        i_stall <= !quiet && ($urandom_range(99) < 36);
    end

    // Directed corners: zero and maximum delay, equal deadlines, re-arming,
    // cancels of armed and idle slots, an empty tick, the unused kind, and a
    // tick that fires all sixteen slots at once.
    task automatic test_directed();
        send_item(K_TICK, 0, 0, 0, 0);
        send_item(K_SET, 0, 0, 8'h00, 32'h0000_0000);
        send_item(K_SET, 15, 31'h7fffffff, 8'hff, 32'hffff_ffff);
        send_item(K_SET, 3, 2, 8'h5a, 32'ha5a5_5a5a);
        send_item(K_SET, 4, 2, 8'ha5, 32'h5a5a_a5a5);
        send_item(K_SET, 3, 1, 8'h33, 32'h3333_3333);   // re-arm ahead of slot 4
        send_item(K_CANCEL, 4, 0, 0, 0);
        send_item(K_CANCEL, 4, 0, 0, 0);
        send_item(K_NONE, 7, 5, 8'h77, 32'h7777_7777);
        send_item(K_TICK, 0, 0, 0, 0);
        send_item(K_TICK, 0, 0, 0, 0);
        send_item(K_CANCEL, 15, 0, 0, 0);
        send_item(K_TICK, 0, 0, 0, 0);
        for (int s = 0; s < NSLOT; s++)
            send_item(K_SET, 4'(s), 1, 8'($urandom), $urandom);
        send_item(K_TICK, 0, 0, 0, 0);
    endtask

    // Pauses the sender until the queue of expected results has emptied.
    task automatic test_pause_until_drained();
        send_item(K_SET, 9, 3, 8'h99, 32'h1234_5678);
        send_item(K_SET, 10, 3, 8'haa, 32'h8765_4321);
        drain_results();
        send_item(K_TICK, 0, 0, 0, 0);
        drain_results();
    endtask

    // Mostly well-formed traffic with short delays so timers keep firing,
    // plus occasional long delays and a sprinkle of the unused kind.
    task automatic test_random(int count);
        int pick;
        logic [30:0] d;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            d = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(12));
            if (pick < 40)
                send_item(K_SET, 4'($urandom_range(15)), d, 8'($urandom), $urandom);
            else if (pick < 58)
                send_item(K_CANCEL, 4'($urandom_range(15)), d, 8'($urandom), $urandom);
            else if (pick < 98)
                send_item(K_TICK, 4'($urandom_range(15)), d, 8'($urandom), $urandom);
            else
                send_item(K_NONE, 4'($urandom_range(15)), d, 8'($urandom), $urandom);
        end
    endtask

    // A long stretch with both sides running flat out.
    task automatic test_back_to_back();
        quiet = 1'b1;
        test_random(60);
        quiet = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_kind = K_NONE;
        i_slot = '0;
        i_delay = '0;
        i_handler = '0;
        i_tag = '0;
        fail_count = 0;
        quiet = 1'b0;
        clock_now = '0;
        for (int s = 0; s < NSLOT; s++) slot_armed[s] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_pause_until_drained();
        test_random(150);
        test_back_to_back();
        test_random(110);

        drain_results();
        // Let any trailing work finish so a stray extra result would show.
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && results_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
